### design/gbfs_pkg.sv
// Shared types and constants of the breadth-first search engine.
package gbfs_pkg;

    localparam int NODE_W     = 4;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = 5;
    localparam int NODE_LIMIT = 16;

    localparam logic [CNT_W-1:0] VC_RESET = 5'd16;

    typedef logic [NODE_W-1:0] node_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_TRAVERSE = 2'd1,
        CMD_PATH     = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_VISIT     = 2'd0,
        KIND_UNREACHED = 2'd1,
        KIND_VERDICT   = 2'd2
    } kind_t;

    // Update request for the adjacency matrix
    typedef struct packed {
        logic  clear;
        logic  add;
        node_t a;
        node_t b;
    } adj_cmd_t;

endpackage

### design/gbfs_lsb_find.sv
// Shared lowest-set-bit finder used for neighbor enqueue and unreached scan.
module gbfs_lsb_find
    import gbfs_pkg::*;
#(
    parameter int NV = 16
)
(
    input  logic [NV-1:0]         vec,
    output logic [$clog2(NV)-1:0] idx,
    output logic [NV-1:0]         onehot,
    output logic                  one_left
);

    localparam int IW = $clog2(NV);

    always_comb
    begin
        // isolate the lowest set bit
        onehot   = vec & (~vec + NV'(1));
        one_left = ((vec & (vec - NV'(1))) == '0);
        idx      = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

endmodule

### design/gbfs_adj_matrix.sv
// Adjacency bit matrix with symmetric edge insert, bulk clear and one row read.
module gbfs_adj_matrix
    import gbfs_pkg::*;
#(
    parameter int NV = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  adj_cmd_t              adj_cmd,
    input  logic [$clog2(NV)-1:0] rd_node,
    output logic [NV-1:0]         rd_row
);

    localparam int IW = $clog2(NV);

    logic [NV-1:0] rows_reg  [NV];
    logic [NV-1:0] rows_next [NV];
    logic [IW-1:0] a_idx;
    logic [IW-1:0] b_idx;

    assign a_idx  = adj_cmd.a[IW-1:0];
    assign b_idx  = adj_cmd.b[IW-1:0];
    assign rd_row = rows_reg[rd_node];

    always_comb
    begin
        for (int r = 0; r < NV; r++)
        begin
            rows_next[r] = rows_reg[r];
            if (adj_cmd.clear)
            begin
                rows_next[r] = '0;
            end
            else if (adj_cmd.add)
            begin
                if (IW'(r) == a_idx)
                begin
                    rows_next[r][b_idx] = 1'b1;
                end
                if (IW'(r) == b_idx)
                begin
                    rows_next[r][a_idx] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NV; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < NV; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

endmodule

### design/graph_bfs_engine.sv
// Top level of the breadth-first search engine over an adjacency bit matrix.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-----------------------------------
//   command   | start / busy            | cmd, node_a, node_b
//   config    | vertex_count_wr         | vertex_count
//   result    | result_valid (strobe)   | node, kind, path_found, last
//
// Add-edge, clear and ignored commands finish in the cycle they are taken;
// busy never rises for them.
// A traversal or path query scans each reached vertex in turn, enqueues its
// unvisited neighbors one by one, then lists any unreached vertices or gives
// the verdict; busy stays high meanwhile. The single lowest-set-bit unit sets
// the pace: one neighbor enqueued or one unreached vertex listed a cycle.
// Reset clears the matrix and the sequencer and sets the vertex count to 16.
// Results are one-cycle strobes; the receiver cannot stall them.
module graph_bfs_engine
    import gbfs_pkg::*;
#(
    parameter int MAX_VERTICES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    input  logic              vertex_count_wr,
    input  logic [CNT_W-1:0]  vertex_count,
    output logic              result_valid,
    output logic [NODE_W-1:0] node,
    output logic [KIND_W-1:0] kind,
    output logic              path_found,
    output logic              last
);

    // Vertex numbers are 4 bits wide, so at most 16 vertices are addressable
    localparam int NV = (MAX_VERTICES < NODE_LIMIT) ? MAX_VERTICES : NODE_LIMIT;
    localparam int IW = $clog2(NV);
    localparam int PW = $clog2(NV + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_EXPAND  = 5'b00100,
        S_UNREACH = 5'b01000,
        S_VERDICT = 5'b10000
    } state_t;

    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] vc_reg,       vc_next;
    logic [NV-1:0]    visited_reg,  visited_next;
    logic [NV-1:0]    newmask_reg,  newmask_next;
    logic [PW-1:0]    head_reg,     head_next;
    logic [PW-1:0]    tail_reg,     tail_next;
    logic             seen_reg,     seen_next;
    logic             query_reg,    query_next;
    logic             res_valid_reg;

    // payload registers
    logic [IW-1:0]    cur_reg;
    logic [IW-1:0]    target_reg;
    node_t            node_reg;
    kind_t            kind_reg;
    logic             found_reg;
    logic             last_reg;
    logic [IW-1:0]    queue_mem [NV];

    logic [CNT_W-1:0] cnt_eff;
    logic [NV-1:0]    valid_mask;
    logic             a_ok;
    logic             b_ok;
    logic [IW-1:0]    a_idx;
    logic [IW-1:0]    b_idx;
    logic             load_start;
    logic             deq;
    logic             q_wr;
    logic             emit;
    node_t            emit_node;
    kind_t            emit_kind;
    logic             emit_found;
    logic             emit_last;
    adj_cmd_t         adj_cmd;
    logic [NV-1:0]    adj_row;
    logic [NV-1:0]    find_vec;
    logic [IW-1:0]    find_idx;
    logic [NV-1:0]    find_onehot;
    logic             find_one_left;
    logic             all_visited;
    logic             accept;

    assign busy         = (state_reg != S_IDLE);
    assign accept       = start && !busy;
    assign result_valid = res_valid_reg;
    assign node         = node_reg;
    assign kind         = kind_reg;
    assign path_found   = found_reg;
    assign last         = last_reg;

    // Effective vertex count saturates at the storage size
    assign cnt_eff = (vc_reg > CNT_W'(NV)) ? CNT_W'(NV) : vc_reg;
    assign a_ok    = CNT_W'(node_a) < cnt_eff;
    assign b_ok    = CNT_W'(node_b) < cnt_eff;
    assign a_idx   = node_a[IW-1:0];
    assign b_idx   = node_b[IW-1:0];

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            valid_mask[i] = CNT_W'(i) < cnt_eff;
        end
    end

    assign all_visited = ((visited_reg & valid_mask) == valid_mask);

    gbfs_adj_matrix #(
        .NV (NV)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .adj_cmd (adj_cmd),
        .rd_node (cur_reg),
        .rd_row  (adj_row)
    );

    // The finder serves the neighbor mask while expanding, else the unvisited set
    assign find_vec = (state_reg == S_EXPAND) ? newmask_reg : (~visited_reg & valid_mask);

    gbfs_lsb_find #(
        .NV (NV)
    ) u_find (
        .vec      (find_vec),
        .idx      (find_idx),
        .onehot   (find_onehot),
        .one_left (find_one_left)
    );

    always_comb
    begin
        state_next   = state_reg;
        vc_next      = vertex_count_wr ? vertex_count : vc_reg;
        visited_next = visited_reg;
        newmask_next = newmask_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        seen_next    = seen_reg;
        query_next   = query_reg;
        load_start   = 1'b0;
        deq          = 1'b0;
        q_wr         = 1'b0;
        emit         = 1'b0;
        emit_node    = NODE_W'(cur_reg);
        emit_kind    = KIND_VISIT;
        emit_found   = 1'b0;
        emit_last    = 1'b0;
        adj_cmd      = '{clear: 1'b0, add: 1'b0, a: node_a, b: node_b};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_CLEAR:
                        begin
                            adj_cmd.clear = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            adj_cmd.add = a_ok && b_ok;
                        end
                        CMD_TRAVERSE, CMD_PATH:
                        begin
                            // Start vertex is taken as already dequeued
                            if (a_ok && (b_ok || cmd_t'(cmd) == CMD_TRAVERSE))
                            begin
                                load_start   = 1'b1;
                                visited_next = NV'(1) << a_idx;
                                head_next    = PW'(1);
                                tail_next    = PW'(1);
                                seen_next    = 1'b0;
                                query_next   = (cmd_t'(cmd) == CMD_PATH);
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                newmask_next = adj_row & ~visited_reg & valid_mask;
                if (query_reg && cur_reg == target_reg)
                begin
                    seen_next = 1'b1;
                end
                state_next = S_EXPAND;
            end

            S_EXPAND:
            begin
                if (newmask_reg != '0)
                begin
                    // enqueue the lowest unvisited neighbor
                    q_wr         = 1'b1;
                    tail_next    = tail_reg + PW'(1);
                    visited_next = visited_reg | find_onehot;
                    newmask_next = newmask_reg & ~find_onehot;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_last = !query_reg && (head_reg == tail_reg) && all_visited;
                    if (head_reg < tail_reg)
                    begin
                        deq        = 1'b1;
                        head_next  = head_reg + PW'(1);
                        state_next = S_SCAN;
                    end
                    else if (query_reg)
                    begin
                        state_next = S_VERDICT;
                    end
                    else if (all_visited)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_UNREACH;
                    end
                end
            end

            S_UNREACH:
            begin
                emit         = 1'b1;
                emit_node    = NODE_W'(find_idx);
                emit_kind    = KIND_UNREACHED;
                emit_last    = find_one_left;
                visited_next = visited_reg | find_onehot;
                if (find_one_left)
                begin
                    state_next = S_IDLE;
                end
            end

            S_VERDICT:
            begin
                emit       = 1'b1;
                emit_node  = NODE_W'(target_reg);
                emit_kind  = KIND_VERDICT;
                emit_found = seen_reg;
                emit_last  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vc_reg        <= VC_RESET;
            visited_reg   <= '0;
            newmask_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            seen_reg      <= 1'b0;
            query_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            visited_reg   <= visited_next;
            newmask_reg   <= newmask_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            seen_reg      <= seen_next;
            query_reg     <= query_next;
            res_valid_reg <= emit;
        end
    end

    // Hold the result beat payload for its one strobe cycle
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            node_reg  <= emit_node;
            kind_reg  <= emit_kind;
            found_reg <= emit_found;
            last_reg  <= emit_last;
        end
    end

    // Current vertex: start vertex on launch, then the queue head on dequeue
    always_ff @(posedge clk)
    begin
        if (load_start)
        begin
            cur_reg    <= a_idx;
            target_reg <= b_idx;
        end
        else if (deq)
        begin
            cur_reg <= queue_mem[head_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
        begin
            queue_mem[tail_reg[IW-1:0]] <= find_idx;
        end
    end

    // Queue never overruns its storage
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXPAND && newmask_reg != '0) |-> tail_reg < PW'(NV))
        else $error("search queue overrun");

    // Dequeue never passes enqueue
    assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    // The final beat of a run leaves the engine ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("engine still busy after final beat");

    // A verdict beat always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_VERDICT) |-> last)
        else $error("verdict beat not marked last");

endmodule

### test/tb_top.sv
// Self-checking testbench for the breadth-first search engine.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbfs_pkg::*;

    localparam int RANDOM_BEATS = 445;
    localparam int QUIET_TAIL   = 70;
    localparam int REPORT_LIMIT = 10;

    // Mirror of the block: adjacency rows, search state and vertex count.
    // Each accepted command beat is turned into the results it must produce.
    class bfs_checker;
        typedef struct packed {
            node_t  node;
            kind_t  kind;
            logic   found;
            logic   last;
        } bfs_result_t;

        logic [15:0]       adj_rows [16];
        logic [15:0]       seen_mask;
        logic              target_hit;
        logic [CNT_W-1:0]  vcount;
        bfs_result_t       due_results [$];
        int                taken;
        int                applied;
        int                searches;
        int                verdicts_hit;
        int                checked;
        int                mismatches;
        int                count_writes;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            seen_mask    = '0;
            target_hit   = 1'b0;
            vcount       = VC_RESET;
            taken        = 0;
            applied      = 0;
            searches     = 0;
            verdicts_hit = 0;
            checked      = 0;
            mismatches   = 0;
            count_writes = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int active_count();
            return (vcount > NODE_LIMIT) ? NODE_LIMIT : int'(vcount);
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            vcount = v;
            count_writes++;
        endfunction

        function void push_due(int v, kind_t k, logic f, logic l);
            bfs_result_t r;
            r.node  = node_t'(v);
            r.kind  = k;
            r.found = f;
            r.last  = l;
            due_results.insert(due_results.size(), r);
        endfunction

        // Visit order from origin; neighbors are scanned in index order
        // and only below the active count.
        function void predict_search(int origin, int target, int n);
            int order [16];
            int head;
            int tail;
            int cur;
            head       = 0;
            tail       = 0;
            seen_mask  = 16'b1 << origin;
            target_hit = 1'b0;
            order[tail] = origin;
            tail++;
            while (head < tail && head < 16)
            begin
                cur = order[head];
                head++;
                if (cur == target)
                    target_hit = 1'b1;
                push_due(cur, KIND_VISIT, 1'b0, 1'b0);
                for (int i = 0; i < n; i++)
                begin
                    if (adj_rows[cur][i] && !seen_mask[i] && tail < 16)
                    begin
                        seen_mask[i] = 1'b1;
                        order[tail]  = i;
                        tail++;
                    end
                end
            end
        endfunction

        // Note one accepted command beat; return 1 if it takes effect.
        function bit note_command(cmd_t c, node_t a, node_t b);
            int n;
            n = active_count();
            taken++;
            if (c == CMD_CLEAR)
            begin
                foreach (adj_rows[i])
                    adj_rows[i] = '0;
                applied++;
                return 1'b1;
            end
            // drop commands naming a vertex outside the active range
            if (int'(a) >= n)
                return 1'b0;
            if (c != CMD_TRAVERSE && int'(b) >= n)
                return 1'b0;
            applied++;
            case (c)
                CMD_ADD:
                begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
                CMD_TRAVERSE:
                begin
                    searches++;
                    predict_search(a, NODE_LIMIT, n);
                    for (int i = 0; i < n; i++)
                        if (!seen_mask[i])
                            push_due(i, KIND_UNREACHED, 1'b0, 1'b0);
                    due_results[due_results.size()-1].last = 1'b1;
                end
                default:
                begin
                    searches++;
                    predict_search(a, b, n);
                    if (target_hit)
                        verdicts_hit++;
                    push_due(b, KIND_VERDICT, target_hit, 1'b1);
                end
            endcase
            return 1'b1;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(logic [NODE_W-1:0] v, logic [KIND_W-1:0] k,
                                   logic f, logic l);
            bfs_result_t due;
            checked++;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result node=%0d kind=%0d found=%0d last=%0d",
                                 v, k, f, l));
                return;
            end
            due = due_results.pop_front();
            if (v !== due.node || k !== due.kind || f !== due.found || l !== due.last)
                report($sformatf("want node=%0d kind=%0d found=%0d last=%0d, got %0d %0d %0d %0d",
                                 due.node, due.kind, due.found, due.last, v, k, f, l));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  cmd = '0;
    logic [NODE_W-1:0] node_a = '0;
    logic [NODE_W-1:0] node_b = '0;
    logic              vertex_count_wr = 1'b0;
    logic [CNT_W-1:0]  vertex_count = '0;
    logic              result_valid;
    logic [NODE_W-1:0] node;
    logic [KIND_W-1:0] kind;
    logic              path_found;
    logic              last;

    bfs_checker sb = new();

    // Idle bursts on the command side; switched off for the closing stretch.
    bit idle_on = 1'b0;
    int phases  = 0;

    graph_bfs_engine #(.MAX_VERTICES(16)) dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .node_a          (node_a),
        .node_b          (node_b),
        .vertex_count_wr (vertex_count_wr),
        .vertex_count    (vertex_count),
        .result_valid    (result_valid),
        .node            (node),
        .kind            (kind),
        .path_found      (path_found),
        .last            (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sample everything at the rising edge: config writes, accepted command
    // beats and result strobes all land in the checker here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(node, kind, path_found, last);
            if (vertex_count_wr)
                sb.set_count(vertex_count);
            if (start && !busy)
                void'(sb.note_command(cmd_t'(cmd), node_a, node_b));
        end
    end

    // Drop start for a burst of cycles.
    task automatic hold_off(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Present one command beat at the falling edge and hold it until taken.
    task automatic send_cmd(cmd_t c, int a, int b);
        @(negedge clk);
        start  <= 1'b1;
        cmd    <= c;
        node_a <= node_t'(a);
        node_b <= node_t'(b);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 6));
    endtask

    // Wait out every pending result, then wait for the sequencer
    // to return to idle.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Update the vertex count only while the engine is idle.
    task automatic write_vertex_count(int v);
        drain();
        @(negedge clk);
        vertex_count_wr <= 1'b1;
        vertex_count    <= CNT_W'(v);
        @(negedge clk);
        vertex_count_wr <= 1'b0;
        phases++;
    endtask

    // Pick a vertex: mostly inside the active range, sometimes anywhere.
    function automatic int pick_vertex(int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic random_phase(int n, int beats, int base);
        int   r;
        cmd_t c;
        if ($urandom_range(0, 1) == 0)
            send_cmd(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
        for (int k = 0; k < beats && sb.taken - base < RANDOM_BEATS; k++)
        begin
            // quiet tail: no idling during the last stretch of the run
            if (sb.taken - base >= RANDOM_BEATS - QUIET_TAIL)
                idle_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 4)
                c = CMD_CLEAR;
            else if (r < 52)
                c = CMD_ADD;
            else if (r < 76)
                c = CMD_TRAVERSE;
            else
                c = CMD_PATH;
            send_cmd(c, pick_vertex(n), pick_vertex(n));
        end
    endtask

    initial
    begin
        int settings [14] = '{16, 1, 2, 9, 31, 5, 16, 12, 17, 3, 16, 7, 24, 16};
        int base;
        int idx;
        int v;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty graph at the reset count of sixteen.
        send_cmd(CMD_TRAVERSE, 0, 0);
        send_cmd(CMD_PATH, 0, 15);
        send_cmd(CMD_PATH, 5, 5);
        send_cmd(CMD_ADD, 0, 15);
        send_cmd(CMD_ADD, 15, 15);     // self loop on the top vertex
        send_cmd(CMD_ADD, 3, 7);
        send_cmd(CMD_ADD, 0, 3);
        send_cmd(CMD_ADD, 7, 12);
        send_cmd(CMD_TRAVERSE, 15, 9); // node_b is a don't-care here
        send_cmd(CMD_PATH, 15, 12);
        send_cmd(CMD_PATH, 12, 0);

        // Shrink the vertex count to 4: the edge between vertices 0 and 15 stays stored but is not scanned.
        write_vertex_count(4);
        send_cmd(CMD_TRAVERSE, 0, 0);
        send_cmd(CMD_ADD, 2, 9);
        send_cmd(CMD_TRAVERSE, 9, 0);
        send_cmd(CMD_PATH, 1, 12);
        send_cmd(CMD_PATH, 2, 3);
        send_cmd(CMD_CLEAR, 0, 0);
        send_cmd(CMD_TRAVERSE, 3, 15);

        // Zero count: every vertex is out of range.
        write_vertex_count(0);
        send_cmd(CMD_TRAVERSE, 0, 0);
        send_cmd(CMD_ADD, 0, 0);
        send_cmd(CMD_PATH, 0, 0);

        // Counts above sixteen saturate.
        write_vertex_count(31);
        send_cmd(CMD_ADD, 14, 15);
        send_cmd(CMD_PATH, 15, 14);

        // Single vertex graph.
        write_vertex_count(1);
        send_cmd(CMD_TRAVERSE, 0, 0);
        send_cmd(CMD_PATH, 0, 0);

        // Random phases, each at its own vertex count.
        base = sb.taken;
        idx  = 0;
        while (sb.taken - base < RANDOM_BEATS)
        begin
            v = settings[idx % 14];
            idx++;
            write_vertex_count(v);
            idle_on = (sb.taken - base < RANDOM_BEATS - QUIET_TAIL)
                      && ($urandom_range(0, 4) != 0);
            random_phase((v > NODE_LIMIT) ? NODE_LIMIT : v, $urandom_range(30, 50), base);
        end

        drain();
        repeat (60)
            @(posedge clk);

        $display("covered %0d command beats (%0d effective), %0d searches (%0d verdicts reached)",
                 sb.taken, sb.applied, sb.searches, sb.verdicts_hit);
        $display("checked %0d results over %0d vertex-count settings, %0d mismatches",
                 sb.checked, phases, sb.mismatches + sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("graph_bfs_engine regression: pass");
        else
            $display("graph_bfs_engine regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("graph_bfs_engine regression: fail");
        $finish;
    end

endmodule
